### design/assert_macros.svh
// Assertion macros for the checker file of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Same-cycle implication, checked at every rising clock edge outside reset.
`define APE_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, checked at every rising clock edge outside reset.
`define APE_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

### design/ape_pkg.sv
// Package with shared constants, the cell control type and saturation helpers.
`timescale 1ns / 1ps
package ape_pkg;

    localparam int TABLE_ENTRIES_DEF = 4096;
    localparam int MAX_CLASSES_DEF   = 16;
    localparam int W_BITS            = 32;
    localparam int A_BITS            = 48;
    localparam int DIV_STEPS         = 48;
    localparam logic [4:0] CLASSES_RESET = 5'd16;

    localparam logic [1:0] REQ_SCORE  = 2'd0;
    localparam logic [1:0] REQ_UPDATE = 2'd1;
    localparam logic [1:0] REQ_TICK   = 2'd2;
    localparam logic [1:0] REQ_AVG    = 2'd3;

    typedef struct packed {
        logic score_add;
        logic shift;
        logic div_load;
        logic div_step;
    } cell_ctrl_t;

    function automatic logic signed [31:0] sat_w(input logic signed [49:0] v);
        logic signed [31:0] r;
        if (v > 50'sd2147483647)
            r = 32'sh7FFFFFFF;
        else if (v < -50'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

    function automatic logic signed [47:0] sat_a(input logic signed [49:0] v);
        logic signed [47:0] r;
        if (v > 50'sd140737488355327)
            r = 48'sh7FFFFFFFFFFF;
        else if (v < -50'sd140737488355328)
            r = 48'sh800000000000;
        else
            r = v[47:0];
        return r;
    endfunction

endpackage

### design/ape_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps
module ape_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### design/ape_cell.sv
// One class cell: score accumulator, shift stage for argmax and a serial divider.
`timescale 1ns / 1ps
module ape_cell (
    input  logic                     clk,
    input  logic                     rst_n,
    input  ape_pkg::cell_ctrl_t      ctrl,
    input  logic signed [31:0]       w_lane,
    input  logic signed [47:0]       a_lane,
    input  logic signed [31:0]       shift_in,
    input  logic [31:0]              divisor,
    output logic signed [31:0]       score,
    output logic signed [47:0]       quotient,
    output logic signed [31:0]       w_avg
);

    logic signed [31:0] score_reg, score_next;
    logic [47:0]        quo_reg, quo_next;
    logic [31:0]        rem_reg, rem_next;
    logic               neg_reg, neg_next;
    logic [32:0]        rem_sh;
    logic [32:0]        rem_diff;
    logic signed [47:0] q_signed;

    always_comb
    begin
        score_next = score_reg;
        if (ctrl.score_add)
        begin
            score_next = ape_pkg::sat_w(50'(score_reg) + 50'(w_lane));
        end
        else if (ctrl.shift)
        begin
            score_next = shift_in;
        end
    end

    // Restoring division of the magnitude, one quotient bit per cycle while div_step is set.
    always_comb
    begin
        rem_sh   = {rem_reg, quo_reg[47]};
        rem_diff = rem_sh - {1'b0, divisor};
        quo_next = quo_reg;
        rem_next = rem_reg;
        neg_next = neg_reg;
        if (ctrl.div_load)
        begin
            neg_next = a_lane[47];
            quo_next = a_lane[47] ? 48'(-a_lane) : 48'(a_lane);
            rem_next = '0;
        end
        else if (ctrl.div_step)
        begin
            if (rem_sh >= {1'b0, divisor})
            begin
                rem_next = rem_diff[31:0];
                quo_next = {quo_reg[46:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh[31:0];
                quo_next = {quo_reg[46:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            score_reg <= '0;
        end
        else
        begin
            score_reg <= score_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        neg_reg <= neg_next;
    end

    assign q_signed = neg_reg ? -$signed(quo_reg) : $signed(quo_reg);
    assign score    = score_reg;
    assign quotient = q_signed;
    assign w_avg    = ape_pkg::sat_w(50'(w_lane) - 50'(q_signed));

endmodule

### design/averaged_perceptron_engine.sv
// Top level of the averaged perceptron engine: sequencer, weight memories, class cells.
`timescale 1ns / 1ps
//  Channel   Direction  Handshake                 Payload
//  request   in         start && !busy           req_type, feature_index, action,
//                                                 increment, last_feature
//  result    out        done (one-cycle strobe)   best_class, best_score, result_kind
//  config    in         cfg_write                 cfg_data (classes in use)
//
// After reset the block runs a clearing pass that zeroes both tables, one row per
// cycle; busy stays high until it finishes.
// A score request reads the row and adds it in the cells; a request marked last then
// shifts the scores through the cell chain into the argmax.
// An update reads the row, multiplies and writes back; a tick stays in the idle state.
// An average request walks the whole table one row at a time, loading, stepping and
// writing back the serial divider in every cell; with a zero step count it gives its result without leaving idle.
// The receiver cannot stall: each result is shown for exactly one cycle with done high.
module averaged_perceptron_engine #(
    parameter int TABLE_ENTRIES = ape_pkg::TABLE_ENTRIES_DEF,
    parameter int MAX_CLASSES   = ape_pkg::MAX_CLASSES_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         req_type,
    input  logic [11:0]        feature_index,
    input  logic [3:0]         action,
    input  logic signed [7:0]  increment,
    input  logic               last_feature,
    input  logic               cfg_write,
    input  logic [4:0]         cfg_data,
    output logic               done,
    output logic [3:0]         best_class,
    output logic signed [31:0] best_score,
    output logic               result_kind
);

    localparam int AW   = $clog2(TABLE_ENTRIES);
    localparam int CW   = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;
    localparam int WROW = MAX_CLASSES * ape_pkg::W_BITS;
    localparam int AROW = MAX_CLASSES * ape_pkg::A_BITS;

    // One-hot sequencer states.
    typedef enum logic [8:0] {
        S_CLEAR  = 9'b000000001,
        S_IDLE   = 9'b000000010,
        S_READ   = 9'b000000100,
        S_UPD    = 9'b000001000,
        S_ARG    = 9'b000010000,
        S_AVG_RD = 9'b000100000,
        S_AVG_DV = 9'b001000000,
        S_AVG_WR = 9'b010000000,
        S_SPARE  = 9'b100000000
    } state_t;

    // Feature indexes wrap modulo the table size by conditional subtraction of
    // scaled copies of the table size, largest first.
    function automatic logic [AW-1:0] wrap_index(input logic [11:0] f);
        logic [63:0] x;
        x = {52'd0, f};
        for (int k = 11; k >= 0; k--)
        begin
            if ((64'(TABLE_ENTRIES) << k) <= 64'd4095)
            begin
                if (x >= (64'(TABLE_ENTRIES) << k))
                begin
                    x = x - (64'(TABLE_ENTRIES) << k);
                end
            end
        end
        return AW'(x);
    endfunction

    state_t             state_reg, state_next;
    logic [4:0]         classes_reg;
    logic [31:0]        step_reg, step_next;
    logic [AW-1:0]      row_reg, row_next;
    logic [5:0]         div_cnt_reg, div_cnt_next;
    logic [CW-1:0]      arg_cnt_reg, arg_cnt_next;
    logic [1:0]         kind_reg, kind_next;
    logic [CW-1:0]      act_reg, act_next;
    logic signed [7:0]  inc_reg, inc_next;
    logic               last_reg, last_next;
    logic signed [40:0] prod_reg, prod_next;
    logic               done_reg, done_next;
    logic [CW-1:0]      best_idx_reg, best_idx_next;
    logic signed [31:0] best_score_reg, best_score_next;
    logic               result_kind_reg, result_kind_next;

    logic               accept;
    logic [6:0]         n_eff;
    logic               rd_en;
    logic [AW-1:0]      rd_addr;
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic [WROW-1:0]    w_wdata, w_rdata;
    logic [AROW-1:0]    a_wdata, a_rdata;
    logic [WROW-1:0]    w_upd_row, w_avg_row;
    logic [AROW-1:0]    a_upd_row, a_avg_row;
    logic signed [31:0] w_sel, w_sum;
    logic signed [47:0] a_sel, a_sum;
    ape_pkg::cell_ctrl_t cell_ctrl;
    logic signed [31:0] cell_score [MAX_CLASSES];

    assign accept = start && !busy;
    assign busy   = (state_reg != S_IDLE);

    // Classes in use clamped to the range 1 .. MAX_CLASSES.
    always_comb
    begin
        if (classes_reg == 5'd0)
            n_eff = 7'd1;
        else if (7'(classes_reg) > 7'(MAX_CLASSES))
            n_eff = 7'(MAX_CLASSES);
        else
            n_eff = 7'(classes_reg);
    end

    // Update path: only the addressed class lane changes.
    assign w_sel = w_rdata[act_reg * ape_pkg::W_BITS +: ape_pkg::W_BITS];
    assign a_sel = a_rdata[act_reg * ape_pkg::A_BITS +: ape_pkg::A_BITS];
    assign w_sum = ape_pkg::sat_w(50'(w_sel) + (50'(inc_reg) <<< 8));
    assign a_sum = ape_pkg::sat_a(50'(a_sel) + (50'(prod_reg) <<< 8));
    assign prod_next = $signed({1'b0, step_reg}) * inc_reg;

    // The class cells, chained for the argmax shift toward cell zero.
    for (genvar i = 0; i < MAX_CLASSES; i++)
    begin : g_cell
        logic signed [31:0] shift_src;
        logic signed [47:0] quo;
        logic signed [31:0] wavg;

        if (i == MAX_CLASSES - 1)
        begin : g_tail
            assign shift_src = '0;
        end
        else
        begin : g_mid
            assign shift_src = cell_score[i + 1];
        end

        ape_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctrl     (cell_ctrl),
            .w_lane   (w_rdata[i * ape_pkg::W_BITS +: ape_pkg::W_BITS]),
            .a_lane   (a_rdata[i * ape_pkg::A_BITS +: ape_pkg::A_BITS]),
            .shift_in (shift_src),
            .divisor  (step_reg),
            .score    (cell_score[i]),
            .quotient (quo),
            .w_avg    (wavg)
        );

        assign w_avg_row[i * ape_pkg::W_BITS +: ape_pkg::W_BITS] = wavg;
        assign a_avg_row[i * ape_pkg::A_BITS +: ape_pkg::A_BITS] = quo;
        assign w_upd_row[i * ape_pkg::W_BITS +: ape_pkg::W_BITS] =
            (32'(i) == 32'(act_reg)) ? w_sum : w_rdata[i * ape_pkg::W_BITS +: ape_pkg::W_BITS];
        assign a_upd_row[i * ape_pkg::A_BITS +: ape_pkg::A_BITS] =
            (32'(i) == 32'(act_reg)) ? a_sum : a_rdata[i * ape_pkg::A_BITS +: ape_pkg::A_BITS];
    end

    ape_ram #(.WIDTH(WROW), .DEPTH(TABLE_ENTRIES)) u_weight_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (w_wdata),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (w_rdata)
    );

    ape_ram #(.WIDTH(AROW), .DEPTH(TABLE_ENTRIES)) u_accum_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (a_wdata),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (a_rdata)
    );

    // Sequencer.
    always_comb
    begin
        state_next       = state_reg;
        step_next        = step_reg;
        row_next         = row_reg;
        div_cnt_next     = div_cnt_reg;
        arg_cnt_next     = arg_cnt_reg;
        kind_next        = kind_reg;
        act_next         = act_reg;
        inc_next         = inc_reg;
        last_next        = last_reg;
        done_next        = 1'b0;
        best_idx_next    = best_idx_reg;
        best_score_next  = best_score_reg;
        result_kind_next = result_kind_reg;
        rd_en            = 1'b0;
        rd_addr          = wrap_index(feature_index);
        wr_en            = 1'b0;
        wr_addr          = row_reg;
        w_wdata          = w_upd_row;
        a_wdata          = a_upd_row;
        cell_ctrl        = '0;

        case (state_reg)
            S_CLEAR:
            begin
                wr_en   = 1'b1;
                w_wdata = '0;
                a_wdata = '0;
                row_next = row_reg + 1'b1;
                if (row_reg == AW'(TABLE_ENTRIES - 1))
                begin
                    row_next   = '0;
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    kind_next = req_type;
                    act_next  = CW'(32'(action));
                    inc_next  = increment;
                    last_next = last_feature;
                    case (req_type)
                        ape_pkg::REQ_SCORE:
                        begin
                            rd_en      = 1'b1;
                            state_next = S_READ;
                        end
                        ape_pkg::REQ_UPDATE:
                        begin
                            // Actions at or above MAX_CLASSES are dropped.
                            if (32'(action) < 32'(MAX_CLASSES))
                            begin
                                rd_en      = 1'b1;
                                row_next   = wrap_index(feature_index);
                                state_next = S_READ;
                            end
                        end
                        ape_pkg::REQ_TICK:
                        begin
                            if (step_reg != 32'hFFFFFFFF)
                            begin
                                step_next = step_reg + 32'd1;
                            end
                        end
                        default:
                        begin
                            if (step_reg == 32'd0)
                            begin
                                done_next        = 1'b1;
                                best_idx_next    = '0;
                                best_score_next  = '0;
                                result_kind_next = 1'b1;
                            end
                            else
                            begin
                                rd_en      = 1'b1;
                                rd_addr    = '0;
                                row_next   = '0;
                                state_next = S_AVG_RD;
                            end
                        end
                    endcase
                end
            end
            S_READ:
            begin
                if (kind_reg == ape_pkg::REQ_SCORE)
                begin
                    cell_ctrl.score_add = 1'b1;
                    arg_cnt_next        = '0;
                    state_next          = last_reg ? S_ARG : S_IDLE;
                end
                else
                begin
                    state_next = S_UPD;
                end
            end
            S_UPD:
            begin
                wr_en      = 1'b1;
                state_next = S_IDLE;
            end
            S_ARG:
            begin
                // Scores leave the chain at cell zero; zeros enter at the tail.
                cell_ctrl.shift = 1'b1;
                if ((7'(arg_cnt_reg) < n_eff) &&
                    ((arg_cnt_reg == '0) || (cell_score[0] > best_score_reg)))
                begin
                    best_idx_next   = arg_cnt_reg;
                    best_score_next = cell_score[0];
                end
                arg_cnt_next = arg_cnt_reg + 1'b1;
                if (arg_cnt_reg == CW'(MAX_CLASSES - 1))
                begin
                    done_next        = 1'b1;
                    result_kind_next = 1'b0;
                    state_next       = S_IDLE;
                end
            end
            S_AVG_RD:
            begin
                cell_ctrl.div_load = 1'b1;
                div_cnt_next       = '0;
                state_next         = S_AVG_DV;
            end
            S_AVG_DV:
            begin
                cell_ctrl.div_step = 1'b1;
                div_cnt_next       = div_cnt_reg + 6'd1;
                if (div_cnt_reg == 6'(ape_pkg::DIV_STEPS - 1))
                begin
                    state_next = S_AVG_WR;
                end
            end
            S_AVG_WR:
            begin
                wr_en   = 1'b1;
                w_wdata = w_avg_row;
                a_wdata = a_avg_row;
                if (row_reg == AW'(TABLE_ENTRIES - 1))
                begin
                    done_next        = 1'b1;
                    best_idx_next    = '0;
                    best_score_next  = '0;
                    result_kind_next = 1'b1;
                    state_next       = S_IDLE;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = row_reg + 1'b1;
                    row_next   = row_reg + 1'b1;
                    state_next = S_AVG_RD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            classes_reg <= ape_pkg::CLASSES_RESET;
            step_reg    <= '0;
            row_reg     <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            row_reg   <= row_next;
            done_reg  <= done_next;
            if (cfg_write)
            begin
                classes_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        div_cnt_reg     <= div_cnt_next;
        arg_cnt_reg     <= arg_cnt_next;
        kind_reg        <= kind_next;
        act_reg         <= act_next;
        inc_reg         <= inc_next;
        last_reg        <= last_next;
        prod_reg        <= prod_next;
        best_idx_reg    <= best_idx_next;
        best_score_reg  <= best_score_next;
        result_kind_reg <= result_kind_next;
    end

    assign done        = done_reg;
    assign best_class  = 4'(32'(best_idx_reg));
    assign best_score  = best_score_reg;
    assign result_kind = result_kind_reg;

endmodule

### design/ape_checker.sv
// Port-level checker for the averaged perceptron engine and its bind statement.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module ape_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               start,
    input logic               busy,
    input logic [1:0]         req_type,
    input logic               last_feature,
    input logic               done,
    input logic [3:0]         best_class,
    input logic signed [31:0] best_score,
    input logic               result_kind
);

    // An averaging result always reports class zero with a zero score.
    `APE_ASSERT_IMP(a_avg_zero, done && result_kind, (best_class == 4'd0) && (best_score == 32'sd0), "averaging result carries nonzero payload")
    // A tick request never occupies the block.
    `APE_ASSERT_NXT(a_tick_free, start && !busy && (req_type == ape_pkg::REQ_TICK), !busy, "tick request left the block busy")
    // A score request without the last mark gives no result.
    `APE_ASSERT_NXT(a_score_quiet, start && !busy && (req_type == ape_pkg::REQ_SCORE) && !last_feature, !done, "unexpected result after a non-final score request")

endmodule

bind averaged_perceptron_engine ape_checker u_ape_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .req_type     (req_type),
    .last_feature (last_feature),
    .done         (done),
    .best_class   (best_class),
    .best_score   (best_score),
    .result_kind  (result_kind)
);

### dv/tb_top.sv
// Self-checking testbench for the averaged perceptron engine.
`timescale 1ns / 1ps
module tb_top;

    typedef struct {
        logic [1:0]        kind;
        logic [11:0]       feat;
        logic [3:0]        act;
        logic signed [7:0] inc;
        logic              last;
    } request_t;

    typedef struct {
        logic [3:0]         cls;
        logic signed [31:0] score;
        logic               kind;
    } outcome_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic [1:0]         req_type = ape_pkg::REQ_SCORE;
    logic [11:0]        feature_index = '0;
    logic [3:0]         action = '0;
    logic signed [7:0]  increment = '0;
    logic               last_feature = 1'b0;
    logic               cfg_write = 1'b0;
    logic [4:0]         cfg_data = '0;
    logic               done;
    logic [3:0]         best_class;
    logic signed [31:0] best_score;
    logic               result_kind;

    averaged_perceptron_engine dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .req_type(req_type), .feature_index(feature_index), .action(action),
        .increment(increment), .last_feature(last_feature),
        .cfg_write(cfg_write), .cfg_data(cfg_data),
        .done(done), .best_class(best_class), .best_score(best_score),
        .result_kind(result_kind)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Requests waiting to be driven and results still owed by the block.
    request_t pending_requests[$];
    outcome_t owed_results[$];
    int       mismatches = 0;
    logic     took = 1'b0;
    int       gap_left = 0;

    // Mirror of the block state. Table entries are keyed by feature * 16 + class;
    // entries never touched read as zero.
    logic signed [31:0] weight_mem[int];
    longint             accum_mem[int];
    logic signed [31:0] score_acc[16];
    logic [31:0]        step_count_m = '0;
    logic [4:0]         classes_m = ape_pkg::CLASSES_RESET;

    int feature_pool[10];

    function automatic longint clamp(longint v, longint lo, longint hi);
        if (v < lo)
            return lo;
        if (v > hi)
            return hi;
        return v;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
        mismatches++;
    endtask

    // Appends a request to the tail of the pending queue.
    task automatic enqueue(request_t r);
        pending_requests = {pending_requests, r};
    endtask

    // Advances the mirror by one accepted request and queues any result it owes.
    task automatic predict_request(request_t r);
        int       base;
        int       k;
        int       n;
        int       top;
        longint   w;
        longint   a;
        outcome_t o;
        base = int'(r.feat) * 16;
        case (r.kind)
            ape_pkg::REQ_SCORE:
            begin
                for (int c = 0; c < 16; c++)
                begin
                    w = weight_mem.exists(base + c) ? longint'(weight_mem[base + c]) : 0;
                    score_acc[c] = 32'(clamp(longint'(score_acc[c]) + w,
                                             -64'sd2147483648, 64'sd2147483647));
                end
                if (r.last)
                begin
                    n = (classes_m == 0) ? 1 : (classes_m > 16 ? 16 : int'(classes_m));
                    top = 0;
                    for (int c = 1; c < n; c++)
                        if (score_acc[c] > score_acc[top])
                            top = c;
                    o.cls = top[3:0];
                    o.score = score_acc[top];
                    o.kind = 1'b0;
                    owed_results = {owed_results, o};
                    foreach (score_acc[c])
                        score_acc[c] = '0;
                end
            end
            ape_pkg::REQ_UPDATE:
            begin
                k = base + int'(r.act);
                w = weight_mem.exists(k) ? longint'(weight_mem[k]) : 0;
                a = accum_mem.exists(k) ? accum_mem[k] : 0;
                weight_mem[k] = 32'(clamp(w + longint'(r.inc) * 256,
                                          -64'sd2147483648, 64'sd2147483647));
                accum_mem[k] = clamp(a + longint'({32'b0, step_count_m}) * longint'(r.inc) * 256,
                                     -64'sd140737488355328, 64'sd140737488355327);
            end
            ape_pkg::REQ_TICK:
            begin
                if (step_count_m != 32'hFFFF_FFFF)
                    step_count_m = step_count_m + 32'd1;
            end
            default:
            begin
                // Averaging divides every accumulated weight by the step count,
                // truncating toward zero, and subtracts it from the weight.
                if (step_count_m != 0)
                    foreach (accum_mem[key])
                    begin
                        a = accum_mem[key] / longint'({32'b0, step_count_m});
                        accum_mem[key] = a;
                        w = weight_mem.exists(key) ? longint'(weight_mem[key]) : 0;
                        weight_mem[key] = 32'(clamp(w - a, -64'sd2147483648,
                                                    64'sd2147483647));
                    end
                o.cls = '0;
                o.score = '0;
                o.kind = 1'b1;
                owed_results = {owed_results, o};
            end
        endcase
    endtask

    // Monitor: checks results first, since a result at this edge always belongs to
    // an earlier request, then mirrors the request and register write taken here.
    always @(posedge clk)
    begin
        request_t r;
        outcome_t o;
        if (rst_n)
        begin
            if (done)
            begin
                if (owed_results.size() == 0)
                    report_mismatch("unexpected result, kind", result_kind, -1);
                else
                begin
                    o = owed_results.pop_front();
                    if (best_class !== o.cls)
                        report_mismatch("best_class", best_class, o.cls);
                    if (best_score !== o.score)
                        report_mismatch("best_score", best_score, o.score);
                    if (result_kind !== o.kind)
                        report_mismatch("result_kind", result_kind, o.kind);
                end
            end
            if (cfg_write)
                classes_m = cfg_data;
            took <= start && !busy;
            if (start && !busy)
            begin
                r.kind = req_type;
                r.feat = feature_index;
                r.act = action;
                r.inc = increment;
                r.last = last_feature;
                predict_request(r);
            end
        end
    end

    // Driver: one assignment to start per falling edge. After a request is taken a
    // random gap is chosen, mostly short, sometimes long.
    always @(negedge clk)
    begin
        request_t r;
        int       roll;
        if (start && !took)
            start <= 1'b1;
        else
        begin
            if (took)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 55)
                    gap_left = 0;
                else if (roll < 90)
                    gap_left = $urandom_range(1, 3);
                else
                    gap_left = $urandom_range(10, 40);
            end
            if (gap_left > 0 || pending_requests.size() == 0 || !rst_n)
            begin
                if (gap_left > 0)
                    gap_left--;
                start <= 1'b0;
            end
            else
            begin
                r = pending_requests.pop_front();
                req_type <= r.kind;
                feature_index <= r.feat;
                action <= r.act;
                increment <= r.inc;
                last_feature <= r.last;
                start <= 1'b1;
            end
        end
    end

    function automatic request_t make_request(logic [1:0] kind, logic [11:0] feat,
                                              logic [3:0] act, logic signed [7:0] inc,
                                              logic last);
        request_t r;
        r.kind = kind;
        r.feat = feat;
        r.act = act;
        r.inc = inc;
        r.last = last;
        return r;
    endfunction

    function automatic logic [11:0] pick_feature();
        if ($urandom_range(0, 3) == 0)
            return 12'($urandom);
        return 12'(feature_pool[$urandom_range(0, 9)]);
    endfunction

    // Waits until every request is taken and every result has come, then lets the
    // block finish any work that owes no result.
    task automatic drain();
        wait (pending_requests.size() == 0);
        @(negedge clk);
        wait (!start);
        wait (owed_results.size() == 0);
        repeat (40) @(posedge clk);
        wait (!busy);
        @(negedge clk);
    endtask

    task automatic write_classes(logic [4:0] value);
        cfg_data <= value;
        cfg_write <= 1'b1;
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    // A score run of random length over a few features, marked last at the end.
    task automatic queue_score_run();
        int len;
        len = $urandom_range(1, 5);
        for (int i = 0; i < len; i++)
            enqueue(make_request(ape_pkg::REQ_SCORE, pick_feature(), 4'($urandom),
                                 8'($urandom), i == len - 1));
    endtask

    task automatic queue_random(int count);
        int roll;
        for (int i = 0; i < count; i++)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 45)
                queue_score_run();
            else if (roll < 80)
                enqueue(make_request(ape_pkg::REQ_UPDATE, pick_feature(),
                                     4'($urandom), 8'($urandom), 1'($urandom)));
            else if (roll < 95)
                enqueue(make_request(ape_pkg::REQ_TICK, 12'($urandom),
                                     4'($urandom), 8'($urandom), 1'($urandom)));
            else
                // A score item without the last marker leaves a partial sum behind.
                enqueue(make_request(ape_pkg::REQ_SCORE, pick_feature(),
                                     4'($urandom), 8'($urandom), 1'b0));
        end
    endtask

    initial
    begin
        foreach (score_acc[c])
            score_acc[c] = '0;
        feature_pool[0] = 0;
        feature_pool[1] = 4095;
        for (int i = 2; i < 10; i++)
            feature_pool[i] = $urandom_range(0, 4095);

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part. Averaging with a zero step count leaves the tables alone.
        enqueue(make_request(ape_pkg::REQ_AVG, 12'd0, 4'd0, 8'sd0, 1'b1));
        enqueue(make_request(ape_pkg::REQ_SCORE, 12'd0, 4'd0, 8'sd0, 1'b1));
        enqueue(make_request(ape_pkg::REQ_UPDATE, 12'd0, 4'd0, 8'sd127, 1'b1));
        enqueue(make_request(ape_pkg::REQ_UPDATE, 12'd4095, 4'd15, -8'sd128, 1'b0));
        enqueue(make_request(ape_pkg::REQ_TICK, 12'hFFF, 4'hF, -8'sd1, 1'b1));
        enqueue(make_request(ape_pkg::REQ_UPDATE, 12'd0, 4'd3, 8'sd127, 1'b0));
        enqueue(make_request(ape_pkg::REQ_UPDATE, 12'd4095, 4'd3, 8'sd127, 1'b0));
        enqueue(make_request(ape_pkg::REQ_TICK, 12'd0, 4'd0, 8'sd0, 1'b0));
        enqueue(make_request(ape_pkg::REQ_UPDATE, 12'd4095, 4'd0, -8'sd5, 1'b0));
        enqueue(make_request(ape_pkg::REQ_SCORE, 12'd0, 4'd0, 8'sd0, 1'b0));
        enqueue(make_request(ape_pkg::REQ_SCORE, 12'd4095, 4'd0, 8'sd0, 1'b1));
        enqueue(make_request(ape_pkg::REQ_SCORE, 12'd4095, 4'd0, 8'sd0, 1'b1));
        drain();

        // Fewest classes in use: only class 0 can win. Zero acts as one.
        write_classes(5'd1);
        enqueue(make_request(ape_pkg::REQ_SCORE, 12'd0, 4'd0, 8'sd0, 1'b1));
        drain();
        write_classes(5'd0);
        enqueue(make_request(ape_pkg::REQ_SCORE, 12'd4095, 4'd0, 8'sd0, 1'b1));
        drain();
        // Values above the class count act as the full count.
        write_classes(5'd31);
        enqueue(make_request(ape_pkg::REQ_SCORE, 12'd0, 4'd0, 8'sd0, 1'b1));
        enqueue(make_request(ape_pkg::REQ_SCORE, 12'd4095, 4'd0, 8'sd0, 1'b1));
        // Averaging with a nonzero step count walks the whole table.
        enqueue(make_request(ape_pkg::REQ_AVG, 12'd0, 4'd0, 8'sd0, 1'b0));
        enqueue(make_request(ape_pkg::REQ_SCORE, 12'd0, 4'd0, 8'sd0, 1'b0));
        enqueue(make_request(ape_pkg::REQ_SCORE, 12'd4095, 4'd0, 8'sd0, 1'b1));
        drain();

        // Random part in phases with different class counts.
        write_classes(5'd16);
        queue_random(50);
        drain();
        write_classes(5'($urandom_range(2, 15)));
        queue_random(50);
        drain();
        write_classes(5'd2);
        queue_random(30);
        drain();
        write_classes(5'($urandom_range(17, 31)));
        queue_random(50);
        enqueue(make_request(ape_pkg::REQ_AVG, 12'($urandom), 4'($urandom),
                             8'($urandom), 1'($urandom)));
        queue_random(20);
        drain();
        write_classes(5'd16);
        queue_random(30);
        drain();

        repeat (50) @(posedge clk);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // Two full-table averages dominate the run.
    initial
    begin
        #20ms;
        $display("RESULT: ERROR");
        $finish;
    end
endmodule
